FILE: hw/rtl/lia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_pkg: shared types and constants of the interpolating activation unit
// Register map, mode codes, configuration record and access-stage control.
// ----------------------------------------------------------------------------
package lia_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int DATA_WIDTH_DEF  = 16;

	localparam int MODE_W      = 3;
	localparam int RANGE_W     = 16;
	localparam int SCALE_W     = 32;
	localparam int SLOPE_W     = 16;
	localparam int ENTRIES_W   = 9;
	localparam int ENTRY_IDX_W = 8;
	localparam int FRAC_W      = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE        = 3'd0,
		REG_RANGE_MIN   = 3'd1,
		REG_RANGE_MAX   = 3'd2,
		REG_INDEX_SCALE = 3'd3,
		REG_LEAKY_SLOPE = 3'd4,
		REG_ENTRIES     = 3'd5
	} cfg_reg_t;

	// codes above MODE_LEAKY all select the table
	localparam logic [MODE_W-1:0] MODE_PASS  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RELU  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LEAKY = 3'd2;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic signed [RANGE_W-1:0] range_min;
		logic signed [RANGE_W-1:0] range_max;
		logic [SCALE_W-1:0]        index_scale;
		logic [SLOPE_W-1:0]        leaky_slope;
		logic [ENTRIES_W-1:0]      entries;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		mode:        MODE_PASS,
		range_min:   16'sh8000,
		range_max:   16'sh7fff,
		index_scale: 32'h0001_0000,
		leaky_slope: 16'd655,
		entries:     9'd256
	};

	// control of the beat sitting in the table access stage
	typedef struct packed {
		logic valid;
		logic write;
		logic table_mode;
		logic odd;
	} acc_ctl_t;

endpackage

FILE: hw/rtl/lia_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_bank: one bank of the sample table
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lia_bank #(
	parameter int DEPTH  = 128,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = 7
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/lia_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_index: front pipeline, stages one to four
// Range clamp, index scaling, fixed activations and table read index.
// ----------------------------------------------------------------------------
module lia_index #(
	parameter int TABLE_DEPTH = lia_pkg::TABLE_DEPTH_DEF,
	parameter int DATA_WIDTH  = lia_pkg::DATA_WIDTH_DEF,
	parameter int AW          = $clog2(lia_pkg::TABLE_DEPTH_DEF)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lia_pkg::cfg_t                      cfg,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               operation,
	input  logic signed [DATA_WIDTH-1:0]       value,
	input  logic [lia_pkg::ENTRY_IDX_W-1:0]    entry_index,
	input  logic signed [DATA_WIDTH-1:0]       entry_value,
	input  logic                               adv,
	output lia_pkg::acc_ctl_t                  ctl_s4,
	output logic [AW-1:0]                      ri_s4,
	output logic [lia_pkg::FRAC_W-1:0]         frac_s4,
	output logic signed [DATA_WIDTH-1:0]       direct_s4,
	output logic [lia_pkg::ENTRY_IDX_W-1:0]    widx_s4,
	output logic signed [DATA_WIDTH-1:0]       wval_s4
);
	import lia_pkg::*;

	localparam int EXT_W  = ((DATA_WIDTH > RANGE_W) ? DATA_WIDTH : RANGE_W) + 1;
	localparam int PROD_W = EXT_W + FRAC_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int LEAK_W = DATA_WIDTH + SLOPE_W + 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

	logic en1, en2, en3, en4;
	logic v1_q, v2_q, v3_q, v4_q;

	// stage one
	logic signed [EXT_W-1:0]      x_ext, rmin_ext, rmax_ext;
	logic                         op_s1, lo_s1, hi_s1;
	logic signed [DATA_WIDTH-1:0] x_s1, wval_s1;
	logic [ENTRY_IDX_W-1:0]       widx_s1;
	logic [EXT_W-1:0]             diff_s1;

	// stage two
	logic                         op_s2, lo_s2, hi_s2;
	logic signed [DATA_WIDTH-1:0] x_s2, wval_s2;
	logic [ENTRY_IDX_W-1:0]       widx_s2;
	logic [PROD_W-1:0]            phi_s2, plo_s2;
	logic signed [LEAK_W-1:0]     leak_s2;

	// stage three
	logic                         op_s3, lo_s3, hi_s3;
	logic signed [DATA_WIDTH-1:0] wval_s3, direct_s3, direct_d;
	logic [ENTRY_IDX_W-1:0]       widx_s3;
	logic [SUM_W-1:0]             idx_s3;
	logic [FRAC_W-1:0]            frac_s3;

	// stage four
	logic                         op_s4, table_s4;
	logic [CNT_W-1:0]             n_eff;
	logic [AW-1:0]                last_idx, ri_d;
	logic                         beyond, to_edge;

	assign en4 = !v4_q || adv;
	assign en3 = !v3_q || en4;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;
	assign item_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (en1) v1_q <= item_valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
		end
	end

	assign x_ext    = EXT_W'(value);
	assign rmin_ext = EXT_W'(cfg.range_min);
	assign rmax_ext = EXT_W'(cfg.range_max);

	always_ff @(posedge clk) begin
		if (en1 && item_valid) begin
			op_s1   <= operation;
			x_s1    <= value;
			widx_s1 <= entry_index;
			wval_s1 <= entry_value;
			lo_s1   <= (x_ext <= rmin_ext);
			hi_s1   <= (x_ext >= rmax_ext);
			diff_s1 <= EXT_W'(x_ext - rmin_ext);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2   <= op_s1;
			x_s2    <= x_s1;
			widx_s2 <= widx_s1;
			wval_s2 <= wval_s1;
			lo_s2   <= lo_s1;
			hi_s2   <= hi_s1;
			phi_s2  <= PROD_W'(diff_s1) * PROD_W'(cfg.index_scale[SCALE_W-1:FRAC_W]);
			plo_s2  <= PROD_W'(diff_s1) * PROD_W'(cfg.index_scale[FRAC_W-1:0]);
			leak_s2 <= LEAK_W'(x_s1) * LEAK_W'($signed({1'b0, cfg.leaky_slope}));
		end
	end

	always_comb begin
		case (cfg.mode)
			MODE_PASS:  direct_d = x_s2;
			MODE_RELU:  direct_d = (x_s2 > 0) ? x_s2 : '0;
			// arithmetic shift floors the scaled product
			MODE_LEAKY: direct_d = (x_s2 > 0) ? x_s2 : leak_s2[FRAC_W +: DATA_WIDTH];
			default:    direct_d = x_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			op_s3     <= op_s2;
			widx_s3   <= widx_s2;
			wval_s3   <= wval_s2;
			lo_s3     <= lo_s2;
			hi_s3     <= hi_s2;
			direct_s3 <= direct_d;
			idx_s3    <= SUM_W'(phi_s2) + SUM_W'(plo_s2 >> FRAC_W);
			frac_s3   <= plo_s2[FRAC_W-1:0];
		end
	end

	always_comb begin
		if (int'(cfg.entries) > TABLE_DEPTH) begin
			n_eff = CNT_W'(TABLE_DEPTH);
		end else if (cfg.entries < ENTRIES_W'(2)) begin
			n_eff = CNT_W'(2);
		end else begin
			n_eff = CNT_W'(cfg.entries);
		end
		last_idx = AW'(n_eff - CNT_W'(1));
		beyond   = (idx_s3 >= SUM_W'(last_idx));
		to_edge  = lo_s3 || hi_s3 || beyond;
		if (lo_s3) begin
			ri_d = '0;
		end else if (hi_s3 || beyond) begin
			ri_d = last_idx;
		end else begin
			ri_d = idx_s3[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			op_s4     <= op_s3;
			widx_s4   <= widx_s3;
			wval_s4   <= wval_s3;
			direct_s4 <= direct_s3;
			ri_s4     <= ri_d;
			// a single entry is an interpolation with zero fraction
			frac_s4   <= to_edge ? '0 : frac_s3;
			table_s4  <= (cfg.mode > MODE_LEAKY);
		end
	end

	assign ctl_s4.valid      = v4_q;
	assign ctl_s4.write      = op_s4;
	assign ctl_s4.table_mode = table_s4;
	assign ctl_s4.odd        = ri_s4[0];

endmodule

FILE: hw/rtl/lia_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_interp: back pipeline, stages five to seven
// Pairs the bank outputs, interpolates and holds the result register.
// ----------------------------------------------------------------------------
module lia_interp #(
	parameter int DATA_WIDTH = lia_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lia_pkg::acc_ctl_t            ctl_s4,
	input  logic [lia_pkg::FRAC_W-1:0]   frac_s4,
	input  logic signed [DATA_WIDTH-1:0] direct_s4,
	input  logic [DATA_WIDTH-1:0]        rd_even,
	input  logic [DATA_WIDTH-1:0]        rd_odd,
	output logic                         adv,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic signed [DATA_WIDTH-1:0] result
);
	import lia_pkg::*;

	localparam int DELTA_W = DATA_WIDTH + 1;
	localparam int IP_W    = DELTA_W + FRAC_W + 1;

	logic en5, en6, en7;
	logic v5_q, v6_q, v7_q;

	logic                         table_s5, odd_s5;
	logic [FRAC_W-1:0]            frac_s5;
	logic signed [DATA_WIDTH-1:0] direct_s5;

	logic signed [DATA_WIDTH-1:0] y0, y1;
	logic signed [DELTA_W-1:0]    delta;

	logic                         table_s6;
	logic signed [DATA_WIDTH-1:0] y0_s6, direct_s6;
	logic signed [IP_W-1:0]       prod_s6;
	logic signed [IP_W-1:0]       ip_shift, ip_sum;

	logic signed [DATA_WIDTH-1:0] result_s7;

	assign en7 = !v7_q || !res_stall;
	assign en6 = !v6_q || en7;
	assign en5 = !v5_q || en6;
	assign adv = en5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v5_q <= 1'b0;
			v6_q <= 1'b0;
			v7_q <= 1'b0;
		end else begin
			// write beats end at the table and give no result
			if (en5) v5_q <= ctl_s4.valid && !ctl_s4.write;
			if (en6) v6_q <= v5_q;
			if (en7) v7_q <= v6_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			table_s5  <= ctl_s4.table_mode;
			odd_s5    <= ctl_s4.odd;
			frac_s5   <= frac_s4;
			direct_s5 <= direct_s4;
		end
	end

	assign y0    = odd_s5 ? $signed(rd_odd)  : $signed(rd_even);
	assign y1    = odd_s5 ? $signed(rd_even) : $signed(rd_odd);
	assign delta = DELTA_W'(y1) - DELTA_W'(y0);

	always_ff @(posedge clk) begin
		if (en6) begin
			table_s6  <= table_s5;
			y0_s6     <= y0;
			direct_s6 <= direct_s5;
			prod_s6   <= IP_W'($signed({1'b0, frac_s5})) * IP_W'(delta);
		end
	end

	assign ip_shift = prod_s6 >>> FRAC_W;
	assign ip_sum   = ip_shift + IP_W'(y0_s6);

	always_ff @(posedge clk) begin
		if (en7) begin
			result_s7 <= table_s6 ? ip_sum[DATA_WIDTH-1:0] : direct_s6;
		end
	end

	assign res_valid = v7_q;
	assign result    = result_s7;

endmodule

FILE: hw/rtl/lut_interpolated_activation_top.sv
`timescale 1ns / 1ps
// throughput: one beat per cycle when nothing stalls; the table sits in two banks
//   (even and odd entries), so both interpolation points come out of one read
// in-range table writes land in stage four in beat order, so later reads always see them
// reset: configuration registers return to their defaults and the pipeline empties;
//   table contents are undefined until written
// ----------------------------------------------------------------------------
// lut_interpolated_activation_top: table-interpolating activation unit
// Pass-through, relu, leaky relu and piecewise-linear table modes on Q4.12.
// ----------------------------------------------------------------------------
module lut_interpolated_activation_top #(
	parameter int TABLE_DEPTH = lia_pkg::TABLE_DEPTH_DEF,
	parameter int DATA_WIDTH  = lia_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lia_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lia_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               operation,
	input  logic signed [DATA_WIDTH-1:0]       value,
	input  logic [lia_pkg::ENTRY_IDX_W-1:0]    entry_index,
	input  logic signed [DATA_WIDTH-1:0]       entry_value,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic signed [DATA_WIDTH-1:0]       result
);
	import lia_pkg::*;

	localparam int AW         = $clog2(TABLE_DEPTH);
	localparam int EVEN_DEPTH = (TABLE_DEPTH + 1) / 2;
	localparam int ODD_DEPTH  = TABLE_DEPTH / 2;
	localparam int EB_W       = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
	localparam int OB_W       = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;

	cfg_t                         cfg_q;
	acc_ctl_t                     ctl_s4;
	logic [AW-1:0]                ri_s4;
	logic [AW:0]                  ri_p1;
	logic [FRAC_W-1:0]            frac_s4;
	logic signed [DATA_WIDTH-1:0] direct_s4, wval_s4;
	logic [ENTRY_IDX_W-1:0]       widx_s4;
	logic                         adv, wr_en, wr_ok;
	logic [EB_W-1:0]              even_raddr, even_waddr;
	logic [OB_W-1:0]              odd_raddr, odd_waddr;
	logic [DATA_WIDTH-1:0]        rd_even, rd_odd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:        cfg_q.mode        <= cfg_data[MODE_W-1:0];
				REG_RANGE_MIN:   cfg_q.range_min   <= cfg_data[RANGE_W-1:0];
				REG_RANGE_MAX:   cfg_q.range_max   <= cfg_data[RANGE_W-1:0];
				REG_INDEX_SCALE: cfg_q.index_scale <= cfg_data[SCALE_W-1:0];
				REG_LEAKY_SLOPE: cfg_q.leaky_slope <= cfg_data[SLOPE_W-1:0];
				REG_ENTRIES:     cfg_q.entries     <= cfg_data[ENTRIES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lia_index #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH),
		.AW          (AW)
	) u_index (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.operation   (operation),
		.value       (value),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.adv         (adv),
		.ctl_s4      (ctl_s4),
		.ri_s4       (ri_s4),
		.frac_s4     (frac_s4),
		.direct_s4   (direct_s4),
		.widx_s4     (widx_s4),
		.wval_s4     (wval_s4)
	);

	// even bank holds entry ri or ri+1, whichever is even; odd bank the other
	assign ri_p1      = {1'b0, ri_s4} + (AW+1)'(1);
	assign even_raddr = EB_W'(ri_p1 >> 1);
	assign odd_raddr  = OB_W'(ri_s4 >> 1);

	assign wr_ok      = (int'(widx_s4) < TABLE_DEPTH);
	assign wr_en      = ctl_s4.valid && ctl_s4.write && adv && wr_ok;
	assign even_waddr = EB_W'(widx_s4 >> 1);
	assign odd_waddr  = OB_W'(widx_s4 >> 1);

	lia_bank #(
		.DEPTH  (EVEN_DEPTH),
		.WIDTH  (DATA_WIDTH),
		.ADDR_W (EB_W)
	) u_bank_even (
		.clk    (clk),
		.we     (wr_en && !widx_s4[0]),
		.waddr  (even_waddr),
		.wdata  (wval_s4),
		.re     (adv),
		.raddr  (even_raddr),
		.rdata  (rd_even)
	);

	lia_bank #(
		.DEPTH  (ODD_DEPTH),
		.WIDTH  (DATA_WIDTH),
		.ADDR_W (OB_W)
	) u_bank_odd (
		.clk    (clk),
		.we     (wr_en && widx_s4[0]),
		.waddr  (odd_waddr),
		.wdata  (wval_s4),
		.re     (adv),
		.raddr  (odd_raddr),
		.rdata  (rd_odd)
	);

	lia_interp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s4     (ctl_s4),
		.frac_s4    (frac_s4),
		.direct_s4  (direct_s4),
		.rd_even    (rd_even),
		.rd_odd     (rd_odd),
		.adv        (adv),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.result     (result)
	);

endmodule

FILE: hw/rtl/lia_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_checker: port-level checks of the activation unit
// Result hold under stall, input hold under stall, upstream flow control and
// configuration handshake.
// ----------------------------------------------------------------------------
module lia_checker #(
	parameter int DATA_WIDTH = lia_pkg::DATA_WIDTH_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic                           item_valid,
	input logic                           item_stall,
	input logic                           operation,
	input logic [DATA_WIDTH-1:0]          value,
	input logic [lia_pkg::ENTRY_IDX_W-1:0] entry_index,
	input logic [DATA_WIDTH-1:0]          entry_value,
	input logic                           res_valid,
	input logic                           res_stall,
	input logic [DATA_WIDTH-1:0]          result
);

	// a stalled result beat stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result beat dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(result))
		else $error("stalled result changed");

	// a stalled input beat stays offered with the same payload
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=>
			item_valid && $stable({operation, value, entry_index, entry_value}))
		else $error("stalled input beat changed");

	// with the output register free or draining, the pipe always takes a beat
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!res_valid || !res_stall) |-> !item_stall)
		else $error("input stalled with free output register");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind lut_interpolated_activation_top lia_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_lia_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.operation   (operation),
	.value       (value),
	.entry_index (entry_index),
	.entry_value (entry_value),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.result      (result)
);
